// File: src/fwbp_pkg.sv
// ----------------------------------------------------------------------------
// fwbp_pkg
// Shared types and constants for the fixed-width bit packer.
// ----------------------------------------------------------------------------
package fwbp_pkg;

  localparam int WORD_BITS    = 32;
  localparam int OFFSET_BITS  = 5;
  localparam int INDEX_BITS   = 16;
  localparam int WIDTH_BITS   = 6;
  localparam int COUNT_BITS   = 17;
  localparam int CFG_IDX_BITS = 1;
  localparam int CFG_BITS     = 17;

  localparam logic [COUNT_BITS-1:0] MAX_ENTRIES  = 17'd65536;
  localparam logic [WIDTH_BITS-1:0] WIDTH_RESET  = 6'd8;
  localparam logic [COUNT_BITS-1:0] LIMIT_RESET  = 17'd65536;
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX    = 6'd32;

  localparam logic [CFG_IDX_BITS-1:0] REG_VALUE_WIDTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ENTRY_LIMIT = 1'b1;

  localparam int QUEUE_DEPTH = 2;

  // Classified item handed from front to back
  typedef struct packed {
    logic                    accepted;
    logic                    spill;
    logic                    exact;
    logic [OFFSET_BITS-1:0]  offset;
    logic [INDEX_BITS-1:0]   word_index;
    logic [WORD_BITS-1:0]    value;
  } fwbp_item_t;

endpackage

// File: src/fwbp_front.sv
// ----------------------------------------------------------------------------
// fwbp_front
// Holds configuration, masks each value and tracks offset, pointer and count.
// ----------------------------------------------------------------------------
module fwbp_front import fwbp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    value_valid,
  input  logic [WORD_BITS-1:0]    value,
  output logic                    value_ready,
  input  logic                    queue_full,
  output logic                    push,
  output fwbp_item_t              item
);

  logic [WIDTH_BITS-1:0]  value_width;
  logic [COUNT_BITS-1:0]  entry_limit;
  logic [OFFSET_BITS-1:0] bit_offset;
  logic [INDEX_BITS-1:0]  word_pointer;
  logic [COUNT_BITS-1:0]  packed_count;

  logic [WIDTH_BITS-1:0]  eff_width;
  logic [COUNT_BITS-1:0]  eff_limit;
  logic [WORD_BITS:0]     mask;
  logic [WIDTH_BITS-1:0]  end_bit;
  logic                   reject;

  assign eff_width = (value_width > WIDTH_MAX) ? WIDTH_MAX : value_width;
  assign eff_limit = (entry_limit > MAX_ENTRIES) ? MAX_ENTRIES : entry_limit;
  assign mask      = ({{WORD_BITS{1'b0}}, 1'b1} << eff_width) - {{WORD_BITS{1'b0}}, 1'b1};
  assign end_bit   = {1'b0, bit_offset} + eff_width;
  assign reject    = packed_count >= eff_limit;

  assign value_ready = !queue_full;
  assign push        = value_valid && value_ready;

  always_comb begin
    item            = '0;
    item.accepted   = !reject;
    item.offset     = bit_offset;
    item.word_index = word_pointer;
    item.spill      = !reject && (end_bit > WIDTH_MAX);
    item.exact      = !reject && (end_bit == WIDTH_MAX);
    item.value      = reject ? '0 : (value & mask[WORD_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_width  <= WIDTH_RESET;
      entry_limit  <= LIMIT_RESET;
      bit_offset   <= '0;
      word_pointer <= '0;
      packed_count <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        REG_VALUE_WIDTH: value_width <= cfg_data[WIDTH_BITS-1:0];
        REG_ENTRY_LIMIT: entry_limit <= cfg_data[COUNT_BITS-1:0];
        default: ;
      endcase
      bit_offset   <= '0;
      word_pointer <= '0;
      packed_count <= '0;
    end else if (push && !reject) begin
      packed_count <= packed_count + 1'b1;
      bit_offset   <= end_bit[OFFSET_BITS-1:0];
      if (end_bit >= WIDTH_MAX) begin
        word_pointer <= word_pointer + 1'b1;
      end
    end
  end

endmodule

// File: src/fwbp_queue.sv
// ----------------------------------------------------------------------------
// fwbp_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module fwbp_queue import fwbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  fwbp_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output fwbp_item_t pop_item
);

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_BITS-1:0] DEPTH = CNT_BITS'(QUEUE_DEPTH);
  localparam logic [PTR_BITS-1:0] LAST  = PTR_BITS'(QUEUE_DEPTH - 1);

  fwbp_item_t          slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;

  assign full      = (count == DEPTH);
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH)
    else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_rise: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not rise on push");
`endif

endmodule

// File: src/fwbp_back.sv
// ----------------------------------------------------------------------------
// fwbp_back
// Merges each item into the partial word and registers the result.
// ----------------------------------------------------------------------------
module fwbp_back import fwbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   clear,
  input  logic                   item_valid,
  input  fwbp_item_t             item,
  output logic                   pop,
  output logic                   result_valid,
  input  logic                   result_ready,
  output logic                   accepted,
  output logic [INDEX_BITS-1:0]  word_index,
  output logic [WORD_BITS-1:0]   word_data,
  output logic                   spill_valid,
  output logic [WORD_BITS-1:0]   spill_data
);

  logic [WORD_BITS-1:0] partial_word;
  logic [WORD_BITS-1:0] merged;
  logic [WORD_BITS-1:0] spilled;

  assign merged  = partial_word | (item.value << item.offset);
  assign spilled = item.value >> (WIDTH_MAX - {1'b0, item.offset});
  assign pop     = item_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      partial_word <= '0;
    end else begin
      if (pop) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (clear) begin
        partial_word <= '0;
      end else if (pop && item.accepted) begin
        if (item.spill) begin
          partial_word <= spilled;
        end else if (item.exact) begin
          partial_word <= '0;
        end else begin
          partial_word <= merged;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      accepted    <= item.accepted;
      word_index  <= item.accepted ? item.word_index : '0;
      word_data   <= item.accepted ? merged : '0;
      spill_valid <= item.spill;
      spill_data  <= item.spill ? spilled : '0;
    end
  end

`ifndef SYNTHESIS
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !accepted) |->
      (word_index == '0 && word_data == '0 && !spill_valid && spill_data == '0))
    else $error("rejected item carries data");
  a_spill_accepted: assert property (@(posedge clk) disable iff (rst)
    (result_valid && spill_valid) |-> accepted)
    else $error("spill on rejected item");
  a_no_spill_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !spill_valid) |-> (spill_data == '0))
    else $error("spill data without spill");
`endif

endmodule

// File: src/fixed_width_bit_packer.sv
// ----------------------------------------------------------------------------
// fixed_width_bit_packer
// Packs values of a configured width, LSB first, into consecutive 32-bit words.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------------
//   value    | value_valid / value_ready  | value
//   result   | result_valid / result_ready| accepted, word_index, word_data,
//            |                            | spill_valid, spill_data
//   config   | cfg_en                     | cfg_index, cfg_data
//
// One item per cycle sustained while result_ready stays high; an accepted value
// passes through the 2-entry item queue and then the result register.
// The front tracks offset, pointer and count; the back holds the partial word.
// A stalled result keeps the back busy while the queue absorbs up to 2 items.
// Reset restores width 8 and limit 65536; a config write clears offset, pointer, count and partial word.
// ----------------------------------------------------------------------------
module fixed_width_bit_packer import fwbp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_en,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    value_valid,
  output logic                    value_ready,
  input  logic [WORD_BITS-1:0]    value,
  output logic                    result_valid,
  input  logic                    result_ready,
  output logic                    accepted,
  output logic [INDEX_BITS-1:0]   word_index,
  output logic [WORD_BITS-1:0]    word_data,
  output logic                    spill_valid,
  output logic [WORD_BITS-1:0]    spill_data
);

  fwbp_item_t front_item;
  fwbp_item_t back_item;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_valid;

  fwbp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_en      (cfg_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .value_valid (value_valid),
    .value       (value),
    .value_ready (value_ready),
    .queue_full  (queue_full),
    .push        (push),
    .item        (front_item)
  );

  fwbp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_valid),
    .pop_item  (back_item)
  );

  fwbp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .clear        (cfg_en),
    .item_valid   (queue_valid),
    .item         (back_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .accepted     (accepted),
    .word_index   (word_index),
    .word_data    (word_data),
    .spill_valid  (spill_valid),
    .spill_data   (spill_data)
  );

endmodule
